// ----- rtl/core/t1d_pkg.sv -----
package t1d_pkg;

    // Phase codes: the role that the next received byte will take.
    localparam logic [2:0] PH_ADDR = 3'd0;
    localparam logic [2:0] PH_CTRL = 3'd1;
    localparam logic [2:0] PH_LEN  = 3'd2;
    localparam logic [2:0] PH_INFO = 3'd3;
    localparam logic [2:0] PH_EPI  = 3'd4;

    // Byte role codes on the result.
    localparam logic [2:0] ROLE_ADDR = 3'd0;
    localparam logic [2:0] ROLE_CTRL = 3'd1;
    localparam logic [2:0] ROLE_LEN  = 3'd2;
    localparam logic [2:0] ROLE_INFO = 3'd3;
    localparam logic [2:0] ROLE_EPI  = 3'd4;

    // Block kinds decoded from the control byte.
    localparam logic [1:0] KIND_I = 2'd0;
    localparam logic [1:0] KIND_R = 2'd1;
    localparam logic [1:0] KIND_S = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_LRC_BAD = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;

    // Control byte masks.
    localparam logic [7:0] PCB_R_BIT   = 8'h80;
    localparam logic [7:0] PCB_TYPE_MASK = 8'hC0;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUNDANCY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INFO   = 1'd1;
    localparam logic [7:0] MAX_INFO_RESET = 8'd254;

    // Epilogue lengths.
    localparam logic [7:0] EPI_LEN_LRC = 8'd1;
    localparam logic [7:0] EPI_LEN_CRC = 8'd2;

    typedef struct packed {
        logic       redundancy_mode;
        logic [7:0] max_info_len;
    } t_cfg;

    typedef struct packed {
        logic [2:0] phase;
        logic [7:0] bytes_left;
        logic [7:0] xor_acc;
        logic [1:0] kind;
    } t_state;

    typedef struct packed {
        logic [7:0] byte_value;
        logic [2:0] byte_role;
        logic [1:0] block_kind;
        logic       block_end;
        logic [1:0] status;
    } t_result;

    // Decode the block type from the control byte.
    function automatic logic [1:0] decode_kind(input logic [7:0] pcb);
        logic [1:0] k;
        if ((pcb & PCB_R_BIT) == 8'h00) begin
            k = KIND_I;
        end else if ((pcb & PCB_TYPE_MASK) == PCB_R_BIT) begin
            k = KIND_R;
        end else begin
            k = KIND_S;
        end
        return k;
    endfunction

endpackage

// ----- rtl/core/t1d_step.sv -----
module t1d_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [7:0]        i_byte,
    input  t1d_pkg::t_cfg     i_cfg,
    output t1d_pkg::t_result  o_result
);

    t1d_pkg::t_state r_state;
    t1d_pkg::t_state n_state;
    logic [7:0]      epi_len;

    assign epi_len = i_cfg.redundancy_mode ? t1d_pkg::EPI_LEN_CRC : t1d_pkg::EPI_LEN_LRC;

    // Tag the byte and compute the next framing state.
    always_comb begin
        n_state             = r_state;
        o_result.byte_value = i_byte;
        o_result.byte_role  = t1d_pkg::ROLE_ADDR;
        o_result.block_kind = r_state.kind;
        o_result.block_end  = 1'b0;
        o_result.status     = t1d_pkg::ST_OK;
        case (r_state.phase)
            t1d_pkg::PH_CTRL: begin
                o_result.byte_role  = t1d_pkg::ROLE_CTRL;
                n_state.kind        = t1d_pkg::decode_kind(i_byte);
                o_result.block_kind = n_state.kind;
                n_state.xor_acc     = r_state.xor_acc ^ i_byte;
                n_state.phase       = t1d_pkg::PH_LEN;
            end
            t1d_pkg::PH_LEN: begin
                o_result.byte_role = t1d_pkg::ROLE_LEN;
                n_state.xor_acc    = r_state.xor_acc ^ i_byte;
                if (i_byte > i_cfg.max_info_len) begin
                    o_result.block_end = 1'b1;
                    o_result.status    = t1d_pkg::ST_TOO_BIG;
                    n_state.phase      = t1d_pkg::PH_ADDR;
                    n_state.bytes_left = 8'd0;
                end else if (i_byte == 8'd0) begin
                    n_state.phase      = t1d_pkg::PH_EPI;
                    n_state.bytes_left = epi_len;
                end else begin
                    n_state.phase      = t1d_pkg::PH_INFO;
                    n_state.bytes_left = i_byte;
                end
            end
            t1d_pkg::PH_INFO: begin
                o_result.byte_role = t1d_pkg::ROLE_INFO;
                n_state.xor_acc    = r_state.xor_acc ^ i_byte;
                if (r_state.bytes_left > 8'd1) begin
                    n_state.bytes_left = r_state.bytes_left - 8'd1;
                end else begin
                    n_state.phase      = t1d_pkg::PH_EPI;
                    n_state.bytes_left = epi_len;
                end
            end
            t1d_pkg::PH_EPI: begin
                o_result.byte_role = t1d_pkg::ROLE_EPI;
                if (r_state.bytes_left > 8'd1) begin
                    n_state.bytes_left = r_state.bytes_left - 8'd1;
                end else begin
                    o_result.block_end = 1'b1;
                    if (!i_cfg.redundancy_mode && (i_byte != r_state.xor_acc)) begin
                        o_result.status = t1d_pkg::ST_LRC_BAD;
                    end
                    n_state.phase      = t1d_pkg::PH_ADDR;
                    n_state.bytes_left = 8'd0;
                end
            end
            default: begin
                // Address byte, also taken for any unused phase code.
                o_result.byte_role  = t1d_pkg::ROLE_ADDR;
                o_result.block_kind = t1d_pkg::KIND_I;
                n_state.xor_acc     = i_byte;
                n_state.bytes_left  = 8'd0;
                n_state.phase       = t1d_pkg::PH_CTRL;
            end
        endcase
    end

    // Framing state advances once per processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= t1d_pkg::PH_ADDR;
            r_state.bytes_left <= 8'd0;
            r_state.xor_acc    <= 8'd0;
            r_state.kind       <= t1d_pkg::KIND_I;
        end else if (i_adv) begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/t1_block_deframer_top.sv -----
// T=1 block deframer. Each received card byte is returned once, tagged with its
// role in the block (address, control, length, information or epilogue), the
// block type decoded from the control byte, an end-of-block flag and a status
// (LRC mismatch, or length above max_info_len which aborts the block). The
// block sustains one byte per clock: the byte sits in an input register while
// the framing logic tags it, and the tagged result is held in an output
// register. While results are taken every cycle, a byte can be accepted every
// cycle; while a result waits, one more byte is held in the input register and
// then the input stalls until the result is taken. An accepted byte moves from
// the input register into the output register. Configuration register 0 selects
// one LRC byte (0) or two unchecked CRC bytes (1) as the epilogue; register 1
// sets the largest accepted information length. Write configuration only while
// no transaction is in flight.
module t1_block_deframer_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [7:0]                    o_byte_value,
    output logic [2:0]                    o_byte_role,
    output logic [1:0]                    o_block_kind,
    output logic                          o_block_end,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [t1d_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data
);

    t1d_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t1d_pkg::t_result r_out;
    t1d_pkg::t_result step_result;
    logic             adv;

    // A byte moves to the output register when that register is free or drains.
    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.redundancy_mode <= 1'b0;
            r_cfg.max_info_len    <= t1d_pkg::MAX_INFO_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                t1d_pkg::CFG_REDUNDANCY: r_cfg.redundancy_mode <= i_cfg_data[0];
                t1d_pkg::CFG_MAX_INFO:   r_cfg.max_info_len    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    t1d_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_result (step_result)
    );

    // Result register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_byte_value = r_out.byte_value;
    assign o_byte_role  = r_out.byte_role;
    assign o_block_kind = r_out.block_kind;
    assign o_block_end  = r_out.block_end;
    assign o_status     = r_out.status;

endmodule
